@@ rtl/u8dec_pkg.sv @@
package u8dec_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned CntW    = 3;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned ResIdxW = 2;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAddrW  = 2;

  localparam logic [CpW-1:0] ReplCp    = 21'h00FFFD;
  localparam logic [CpW-1:0] MinCp2    = 21'h000080;
  localparam logic [CpW-1:0] MinCp3    = 21'h000800;
  localparam logic [CpW-1:0] MinCp4    = 21'h010000;
  localparam logic [CpW-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] MaxCp     = 21'h10FFFF;

  localparam logic [CntW-1:0] Len1 = 3'd1;
  localparam logic [CntW-1:0] Len2 = 3'd2;
  localparam logic [CntW-1:0] Len3 = 3'd3;
  localparam logic [CntW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic            malformed;
    logic [CntW-1:0] byte_count;
  } res_t;

  typedef struct packed {
    logic [ResIdxW-1:0]     cnt;
    res_t [MaxRes-1:0]      res;
  } group_t;

endpackage

@@ rtl/u8dec_front.sv @@
module u8dec_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_text_i,
  output logic            push_o,
  output u8dec_pkg::group_t push_data_o,
  input  logic            q_ready_i
);
  import u8dec_pkg::*;

  logic [CpW-1:0]  pv_q, pv_d;
  logic [CntW-1:0] el_q, el_d;
  logic [CntW-1:0] bs_q, bs_d;

  logic                 fire;
  logic [ResIdxW-1:0]   n_v;
  res_t [MaxRes-1:0]    res_v;
  logic [CpW-1:0]       cp_v;
  logic [CntW-1:0]      bs_v;
  logic                 bad_v;
  logic                 start_v;

  assign in_ready_o = q_ready_i;
  assign fire       = in_valid_i && q_ready_i;

  always_comb begin
    pv_d    = pv_q;
    el_d    = el_q;
    bs_d    = bs_q;
    n_v     = '0;
    res_v   = '0;
    cp_v    = {pv_q[CpW-7:0], in_byte_i[5:0]};
    bs_v    = bs_q + Len1;
    bad_v   = 1'b0;
    start_v = 1'b0;

    if (el_q != '0) begin
      if (in_byte_i[7:6] == 2'b10) begin
        pv_d = cp_v;
        bs_d = bs_v;
        if (bs_v >= el_q) begin
          if ((el_q == Len2 && cp_v < MinCp2) || (el_q == Len3 && cp_v < MinCp3) ||
              (el_q == Len4 && cp_v < MinCp4)) begin
            bad_v = 1'b1;
          end
          if (cp_v >= SurrLo && cp_v <= SurrHi) begin
            bad_v = 1'b1;
          end
          if (cp_v > MaxCp) begin
            bad_v = 1'b1;
          end
          res_v[n_v] = '{code_point: bad_v ? ReplCp : cp_v, malformed: bad_v,
                         byte_count: el_q};
          n_v  = n_v + 1'b1;
          pv_d = '0;
          el_d = '0;
          bs_d = '0;
        end
      end else begin
        res_v[n_v] = '{code_point: ReplCp, malformed: 1'b1, byte_count: bs_q};
        n_v     = n_v + 1'b1;
        pv_d    = '0;
        el_d    = '0;
        bs_d    = '0;
        start_v = 1'b1;
      end
    end else begin
      start_v = 1'b1;
    end

    if (start_v) begin
      if (in_byte_i < 8'h80) begin
        res_v[n_v] = '{code_point: {13'd0, in_byte_i}, malformed: 1'b0, byte_count: Len1};
        n_v = n_v + 1'b1;
      end else if (in_byte_i inside {[8'hC2:8'hDF]}) begin
        pv_d = {16'd0, in_byte_i[4:0]};
        el_d = Len2;
        bs_d = Len1;
      end else if (in_byte_i inside {[8'hE0:8'hEF]}) begin
        pv_d = {17'd0, in_byte_i[3:0]};
        el_d = Len3;
        bs_d = Len1;
      end else if (in_byte_i inside {[8'hF0:8'hF4]}) begin
        pv_d = {18'd0, in_byte_i[2:0]};
        el_d = Len4;
        bs_d = Len1;
      end else begin
        res_v[n_v] = '{code_point: ReplCp, malformed: 1'b1, byte_count: Len1};
        n_v = n_v + 1'b1;
      end
    end

    if (end_of_text_i && el_d != '0) begin
      res_v[n_v] = '{code_point: ReplCp, malformed: 1'b1, byte_count: bs_d};
      n_v  = n_v + 1'b1;
      pv_d = '0;
      el_d = '0;
      bs_d = '0;
    end
  end

  assign push_o           = fire && (n_v != '0);
  assign push_data_o.cnt  = n_v;
  assign push_data_o.res  = res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      el_q <= '0;
      bs_q <= '0;
    end else if (fire) begin
      pv_q <= pv_d;
      el_q <= el_d;
      bs_q <= bs_d;
    end
  end

endmodule

@@ rtl/u8dec_queue.sv @@
module u8dec_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8dec_pkg::group_t push_data_i,
  output logic              ready_o,
  output logic              not_empty_o,
  output u8dec_pkg::group_t head_o,
  input  logic              pop_i
);
  import u8dec_pkg::*;

  group_t            mem_q [QDepth];
  logic [QAddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAddrW:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign ready_o     = count_q != QDepth[QAddrW:0];
  assign not_empty_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && ready_o;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/u8dec_back.sv @@
module u8dec_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              not_empty_i,
  input  u8dec_pkg::group_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [20:0]       code_point_o,
  output logic              malformed_o,
  output logic [2:0]        byte_count_o,
  output logic              last_of_item_o
);
  import u8dec_pkg::*;

  logic               valid_q, valid_d;
  res_t               res_q;
  logic               last_q;
  logic [ResIdxW-1:0] idx_q, idx_d;
  logic               load;
  logic               take;
  logic               is_last;

  assign load    = !valid_q || out_ready_i;
  assign take    = load && not_empty_i;
  assign is_last = (idx_q + 1'b1) == head_i.cnt;
  assign pop_o   = take && is_last;

  always_comb begin
    valid_d = load ? not_empty_i : valid_q;
    idx_d   = idx_q;
    if (take) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q  <= head_i.res[idx_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o    = valid_q;
  assign code_point_o   = res_q.code_point;
  assign malformed_o    = res_q.malformed;
  assign byte_count_o   = res_q.byte_count;
  assign last_of_item_o = last_q;

endmodule

@@ rtl/utf8_validating_decoder.sv @@
// UTF-8 decoder with validation. Takes one text byte per transfer and gives zero to two
// results per byte (a sequence cut short by a new byte that is not a continuation, followed
// by that byte's own result or by its truncation at end of text); last_of_item marks the
// final result of a byte. The front decodes one byte per cycle while the queue has room
// and writes its results as one group into a four-entry queue; the back drains one result
// per cycle into the output register while it is empty or read, so a byte that yields
// k results takes k output transfers. Input stalls only when the queue is full.
module utf8_validating_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic        malformed_o,
  output logic [2:0]  byte_count_o,
  output logic        last_of_item_o
);
  import u8dec_pkg::*;

  logic   push;
  group_t push_data;
  logic   q_ready;
  logic   q_not_empty;
  group_t q_head;
  logic   pop;

  u8dec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .q_ready_i     (q_ready)
  );

  u8dec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .not_empty_o (q_not_empty),
    .head_o      (q_head),
    .pop_i       (pop)
  );

  u8dec_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .not_empty_i    (q_not_empty),
    .head_i         (q_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_o   (code_point_o),
    .malformed_o    (malformed_o),
    .byte_count_o   (byte_count_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
